// ===== sv/sfa_pkg.sv =====
// shared constants, types and helpers for the spring force accumulator
package sfa_pkg;

	localparam int NUM_PARTICLES = 4096;
	localparam int IDX_W = $clog2(NUM_PARTICLES);
	localparam int PART_W = 12;
	localparam int POS_W = 32;
	localparam int DIFF_W = POS_W + 1;
	localparam int SUM_W = 2 * DIFF_W + 2;
	localparam int ROOT_W = 35;
	localparam int FMAG_W = 31;
	localparam int NUM_W = FMAG_W + DIFF_W;
	localparam int ACC_W = 32;

	localparam logic [1:0] CFG_STIFFNESS = 2'd0;
	localparam logic [1:0] CFG_GRAVITY = 2'd1;
	localparam logic [1:0] CFG_DEADBAND = 2'd2;

	localparam logic [31:0] STIFFNESS_RST = 32'd65536;
	localparam logic [31:0] GRAVITY_RST = 32'd642253;
	localparam logic [15:0] DEADBAND_RST = 16'd66;

	localparam logic OP_SPRING = 1'b0;
	localparam logic OP_FRAME = 1'b1;

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic [ACC_W*3-1:0] acc_vec_t;

	function automatic acc_t sat32(input logic signed [ACC_W:0] v);
		if (v[ACC_W] != v[ACC_W-1]) begin
			sat32 = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			sat32 = v[ACC_W-1:0];
		end
	endfunction

endpackage

// ===== sv/sfa_store.sv =====
// accumulator memory, one write port and one registered read port
module sfa_store (
	input  logic                     clk,
	input  logic                     we,
	input  logic [sfa_pkg::IDX_W-1:0] waddr,
	input  sfa_pkg::acc_vec_t        wdata,
	input  logic                     re,
	input  logic [sfa_pkg::IDX_W-1:0] raddr,
	output sfa_pkg::acc_vec_t        rdata
);
	import sfa_pkg::*;

	acc_vec_t mem [NUM_PARTICLES];
	acc_vec_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== sv/sfa_sqrt.sv =====
// iterative integer square root, one root bit per cycle
module sfa_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sfa_pkg::SUM_W-1:0]  radicand,
	output logic                       done,
	output logic [sfa_pkg::ROOT_W-1:0] root
);
	import sfa_pkg::*;

	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] sub;

	assign sub = {(REM_W + 2 - ROOT_W - 2)'(0), root_q, 2'b01};
	assign trial = {rem_q, rad_q[RAD_W-1 -: 2]} - sub;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= {(RAD_W - SUM_W)'(0), radicand};
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (!trial[REM_W+1]) begin
				rem_q <= trial[REM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// ===== sv/sfa_div.sv =====
// three-lane restoring divider, shared divisor, one quotient bit per cycle
module sfa_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sfa_pkg::NUM_W-1:0]  num [3],
	input  logic [sfa_pkg::ROOT_W-1:0] den,
	output logic                       done,
	output logic [sfa_pkg::FMAG_W-1:0] quo [3]
);
	import sfa_pkg::*;

	localparam int CNT_W = $clog2(FMAG_W + 1);

	logic [ROOT_W-1:0] rem_q [3];
	logic [FMAG_W-1:0] sh_q [3];
	logic [ROOT_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [ROOT_W:0] t [3];
	logic [ROOT_W:0] td [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t[i] = {rem_q[i], sh_q[i][FMAG_W-1]};
			td[i] = t[i] - {1'b0, den_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(FMAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= ROOT_W'(num[i][NUM_W-1:FMAG_W]);
				sh_q[i] <= num[i][FMAG_W-1:0];
			end
		end else if (busy_q) begin
			for (int i = 0; i < 3; i++) begin
				if (!td[i][ROOT_W]) begin
					rem_q[i] <= td[i][ROOT_W-1:0];
					sh_q[i] <= {sh_q[i][FMAG_W-2:0], 1'b1};
				end else begin
					rem_q[i] <= t[i][ROOT_W-1:0];
					sh_q[i] <= {sh_q[i][FMAG_W-2:0], 1'b0};
				end
			end
		end
	end

	assign done = done_q;
	assign quo = sh_q;
endmodule

// ===== sv/spring_force_accumulator.sv =====
// top level of the spring force accumulator
// usage:
// input words enter on in_valid / in_stall; in_stall is high while an item is
// being worked on, so one item is processed at a time.
// a frame start word writes (0, -gravity, 0) for particle_a and gives one
// result word with last set. a spring word gives two result words:
// particle_a first, then particle_b with last set. after acceptance it
// squares and sums the three differences, runs the square root (start, 35
// root bits, done), works out the stretch and force scaling, runs the
// three-lane divider (start, 31 quotient bits, done) and does the
// accumulator read-modify-write for particle_a and then particle_b; the
// next word is taken once the second result is loaded. a spring with no
// force skips the scaling and division.
// results sit in an output register; a stalled receiver holds the result
// and the block waits before writing the next accumulator.
// configuration writes on cfg_en / cfg_index / cfg_data take effect at once.
// reset clears control state and loads the register defaults; accumulators
// are undefined until written by a frame start word.
module spring_force_accumulator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_en,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic [11:0]        particle_a,
	input  logic [11:0]        particle_b,
	input  logic signed [31:0] pos_a_x,
	input  logic signed [31:0] pos_a_y,
	input  logic signed [31:0] pos_a_z,
	input  logic signed [31:0] pos_b_x,
	input  logic signed [31:0] pos_b_y,
	input  logic signed [31:0] pos_b_z,
	input  logic [30:0]        rest_length,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [11:0]        particle,
	output logic signed [31:0] acc_x,
	output logic signed [31:0] acc_y,
	output logic signed [31:0] acc_z,
	output logic               last
);
	import sfa_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_FRAME, ST_SQ, ST_SQRT_GO, ST_SQRT_WAIT, ST_STRETCH, ST_FMUL,
		ST_FSAT, ST_PMUL, ST_DIV_GO, ST_DIV_WAIT, ST_RD_A, ST_MOD_A, ST_RD_B, ST_MOD_B
	} state_t;

	state_t state_q;
	logic [31:0] stiffness_q;
	logic [31:0] gravity_q;
	logic [15:0] deadband_q;

	logic [PART_W-1:0] pa_q;
	logic [PART_W-1:0] pb_q;
	logic signed [DIFF_W-1:0] diff_q [3];
	logic [30:0] rest_q;
	logic [1:0] cnt_q;
	logic [2*DIFF_W-1:0] prod_q;
	logic [SUM_W-1:0] sum_q;
	logic [ROOT_W-1:0] smag_q;
	logic fzero_q;
	logic fneg_q;
	logic [66:0] fprod_q;
	logic [FMAG_W-1:0] fmag_q;
	logic [NUM_W-1:0] num_q [3];

	logic out_valid_q;
	logic [PART_W-1:0] particle_q;
	acc_t acc_x_q;
	acc_t acc_y_q;
	acc_t acc_z_q;
	logic last_q;

	logic [DIFF_W-1:0] mag_w [3];
	logic [DIFF_W-1:0] sq_mag;
	logic sqrt_start;
	logic sqrt_done;
	logic [ROOT_W-1:0] root_w;
	logic signed [ROOT_W:0] s_w;
	logic [ROOT_W-1:0] smag_w;
	logic div_start;
	logic div_done;
	logic [FMAG_W-1:0] quo_w [3];
	acc_t f_w [3];
	logic out_free;
	logic out_load;
	acc_t new_acc [3];
	acc_vec_t rdata_w;
	acc_t rd_acc [3];
	logic mem_we;
	logic mem_re;
	logic [IDX_W-1:0] mem_waddr;
	logic [IDX_W-1:0] mem_raddr;
	acc_t neg_grav;
	logic [PART_W-1:0] load_particle;
	logic load_last;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_w[i] = diff_q[i][DIFF_W-1] ? DIFF_W'(-diff_q[i]) : DIFF_W'(diff_q[i]);
		end
	end

	assign sq_mag = mag_w[(cnt_q == 2'd3) ? 2'd0 : cnt_q];
	assign sqrt_start = (state_q == ST_SQRT_GO);
	assign div_start = (state_q == ST_DIV_GO);
	assign s_w = $signed({1'b0, root_w}) - $signed({5'b0, rest_q});
	assign smag_w = s_w[ROOT_W] ? ROOT_W'(-s_w) : ROOT_W'(s_w);
	assign neg_grav = gravity_q[31] ? {1'b1, 31'b0} : acc_t'(-$signed({1'b0, gravity_q}));

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (fzero_q) begin
				f_w[i] = '0;
			end else if (fneg_q != diff_q[i][DIFF_W-1]) begin
				f_w[i] = -$signed({1'b0, quo_w[i]});
			end else begin
				f_w[i] = $signed({1'b0, quo_w[i]});
			end
			rd_acc[i] = rdata_w[ACC_W*i +: ACC_W];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (state_q == ST_MOD_A) begin
				new_acc[i] = sat32(33'(rd_acc[i]) + 33'(f_w[i]));
			end else if (state_q == ST_MOD_B) begin
				new_acc[i] = sat32(33'(rd_acc[i]) - 33'(f_w[i]));
			end else begin
				new_acc[i] = (i == 1) ? neg_grav : '0;
			end
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign out_load = out_free &&
		(state_q == ST_FRAME || state_q == ST_MOD_A || state_q == ST_MOD_B);
	assign load_particle = (state_q == ST_MOD_B) ? pb_q : pa_q;
	assign load_last = (state_q != ST_MOD_A);
	assign mem_we = out_load;
	assign mem_waddr = IDX_W'(load_particle);
	assign mem_re = (state_q == ST_RD_A) || (state_q == ST_RD_B);
	assign mem_raddr = (state_q == ST_RD_B) ? IDX_W'(pb_q) : IDX_W'(pa_q);

	sfa_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.radicand(sum_q),
		.done    (sqrt_done),
		.root    (root_w)
	);

	sfa_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num_q),
		.den   (root_w),
		.done  (div_done),
		.quo   (quo_w)
	);

	sfa_store u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata({new_acc[2], new_acc[1], new_acc[0]}),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(rdata_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiffness_q <= STIFFNESS_RST;
			gravity_q <= GRAVITY_RST;
			deadband_q <= DEADBAND_RST;
		end else if (cfg_en) begin
			case (cfg_index)
				CFG_STIFFNESS: stiffness_q <= cfg_data;
				CFG_GRAVITY: gravity_q <= cfg_data;
				CFG_DEADBAND: deadband_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q <= '0;
						state_q <= (operation == OP_FRAME) ? ST_FRAME : ST_SQ;
					end
				end
				ST_FRAME: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 2'd3) begin
						state_q <= ST_SQRT_GO;
					end
				end
				ST_SQRT_GO: state_q <= ST_SQRT_WAIT;
				ST_SQRT_WAIT: begin
					if (sqrt_done) begin
						state_q <= ST_STRETCH;
					end
				end
				ST_STRETCH: begin
					if (root_w == '0 || smag_w < ROOT_W'(deadband_q)) begin
						state_q <= ST_RD_A;
					end else begin
						state_q <= ST_FMUL;
					end
				end
				ST_FMUL: state_q <= ST_FSAT;
				ST_FSAT: begin
					cnt_q <= '0;
					state_q <= ST_PMUL;
				end
				ST_PMUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 2'd2) begin
						state_q <= ST_DIV_GO;
					end
				end
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_done) begin
						state_q <= ST_RD_A;
					end
				end
				ST_RD_A: state_q <= ST_MOD_A;
				ST_MOD_A: begin
					if (out_free) begin
						state_q <= ST_RD_B;
					end
				end
				ST_RD_B: state_q <= ST_MOD_B;
				ST_MOD_B: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			pa_q <= particle_a;
			pb_q <= particle_b;
			rest_q <= rest_length;
			diff_q[0] <= DIFF_W'(pos_a_x) - DIFF_W'(pos_b_x);
			diff_q[1] <= DIFF_W'(pos_a_y) - DIFF_W'(pos_b_y);
			diff_q[2] <= DIFF_W'(pos_a_z) - DIFF_W'(pos_b_z);
			sum_q <= '0;
		end
		if (state_q == ST_SQ) begin
			prod_q <= sq_mag * sq_mag;
			if (cnt_q != 2'd0) begin
				sum_q <= sum_q + SUM_W'(prod_q);
			end
		end
		if (state_q == ST_STRETCH) begin
			smag_q <= smag_w;
			fneg_q <= !s_w[ROOT_W] && (s_w != '0);
			fzero_q <= (root_w == '0) || (smag_w < ROOT_W'(deadband_q));
		end
		if (state_q == ST_FMUL) begin
			fprod_q <= stiffness_q * smag_q;
		end
		if (state_q == ST_FSAT) begin
			fmag_q <= (fprod_q[66:16] > 51'h7FFFFFFF) ? {FMAG_W{1'b1}} : fprod_q[46:16];
		end
		if (state_q == ST_PMUL) begin
			num_q[cnt_q] <= fmag_q * mag_w[cnt_q];
		end
		if (out_load) begin
			particle_q <= load_particle;
			acc_x_q <= new_acc[0];
			acc_y_q <= new_acc[1];
			acc_z_q <= new_acc[2];
			last_q <= load_last;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign particle = particle_q;
	assign acc_x = acc_x_q;
	assign acc_y = acc_y_q;
	assign acc_z = acc_z_q;
	assign last = last_q;

	a_we_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> out_free)
		else $error("accumulator written while result register full");

	a_first_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !last_q |-> state_q != ST_IDLE)
		else $error("first endpoint result pending with no second");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV_WAIT)
		else $error("divider finished outside its wait state");

	a_sqrt_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> state_q == ST_SQRT_WAIT)
		else $error("square root finished outside its wait state");
endmodule
